// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the packet byte deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of i_clk outside reset.
`define PBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that cond at one edge implies result at the next edge, outside reset.
`define PBD_ASSERT_NEXT(lbl, cond, result, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (result)) else $error(msg);

`endif

// File: rtl/pbd_pkg.sv
// Types and constants for the packet byte deframer.
`timescale 1ns / 1ps
`default_nettype none

package pbd_pkg;

    localparam logic [7:0] START_BYTE_RESET = 8'hAA;

    // Header field sizes in bytes, counted from zero.
    localparam logic [1:0] ID_LAST_INDEX  = 2'd3;
    localparam logic [1:0] LEN_LAST_INDEX = 2'd1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ID   = 3'd1,
        PH_TYPE = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    typedef struct packed {
        logic [31:0] node_id;
        logic [7:0]  msg_type;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/packet_byte_deframer.sv
// Top level of the packet byte deframer: header parsing and result buffering.
//
// Usage:
// The receive channel (i_rx_valid, o_rx_stall, i_rx_byte) takes one byte per
// beat. The block waits for a byte equal to the start byte register, then
// gathers a 4-byte big-endian node identifier, one message type byte and a
// 2-byte big-endian payload length. Each payload byte then leaves on the
// result channel (o_out_valid, i_out_stall) as one beat tagged with the
// header; the final payload byte carries o_last. A packet of length zero
// gives one beat with o_has_data clear and o_last set.
// Each result is registered in the output register, or in the skid stage
// when the receiver stalls. The block takes one byte per cycle while
// o_rx_stall is low. Reset clears the parser to idle, empties the output
// register and the skid stage, and loads the start byte with 0xAA. When the
// receiver stalls, the output register holds its beat and one more result is
// kept in a skid stage; only then does o_rx_stall rise, and it falls as the
// skid drains. The user must write the start byte register (i_cfg_we,
// i_cfg_data) only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module packet_byte_deframer
    import pbd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_node_id,
    output logic [7:0]       o_msg_type,
    output logic [15:0]      o_payload_length,
    output logic [7:0]       o_data_byte,
    output logic             o_has_data,
    output logic             o_last
);

    // Parser state.
    t_phase      r_phase, n_phase;
    logic [1:0]  r_field_idx, n_field_idx;
    logic [31:0] r_id_accum, n_id_accum;
    logic [7:0]  r_type_hold, n_type_hold;
    logic [15:0] r_length_accum, n_length_accum;
    logic [15:0] r_payload_count, n_payload_count;
    logic [7:0]  r_start_byte;

    // Output register and skid stage.
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        rx_accept;
    logic        res_valid;
    t_result     res;
    logic        out_free;
    logic [15:0] count_inc;

    assign o_rx_stall = r_skid_valid;
    assign rx_accept  = i_rx_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign count_inc  = r_payload_count + 16'd1;

    // One byte moves the parser by one step and may produce one result.
    always_comb begin
        n_phase         = r_phase;
        n_field_idx     = r_field_idx;
        n_id_accum      = r_id_accum;
        n_type_hold     = r_type_hold;
        n_length_accum  = r_length_accum;
        n_payload_count = r_payload_count;
        res_valid       = 1'b0;
        res             = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_rx_byte == r_start_byte) begin
                    n_field_idx     = 2'd0;
                    n_id_accum      = '0;
                    n_type_hold     = '0;
                    n_length_accum  = '0;
                    n_payload_count = '0;
                    n_phase         = PH_ID;
                end
            end
            PH_ID: begin
                n_id_accum  = {r_id_accum[23:0], i_rx_byte};
                n_field_idx = r_field_idx + 2'd1;
                if (r_field_idx == ID_LAST_INDEX) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type_hold = i_rx_byte;
                n_field_idx = 2'd0;
                n_phase     = PH_LEN;
            end
            PH_LEN: begin
                n_length_accum = {r_length_accum[7:0], i_rx_byte};
                n_field_idx    = r_field_idx + 2'd1;
                if (r_field_idx == LEN_LAST_INDEX) begin
                    n_field_idx     = 2'd0;
                    n_payload_count = '0;
                    if (n_length_accum == 16'd0) begin
                        // An empty packet still gives one closing result.
                        n_phase            = PH_IDLE;
                        res_valid          = 1'b1;
                        res.node_id        = r_id_accum;
                        res.msg_type       = r_type_hold;
                        res.payload_length = 16'd0;
                        res.data_byte      = 8'd0;
                        res.has_data       = 1'b0;
                        res.last           = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_payload_count    = count_inc;
                res_valid          = 1'b1;
                res.node_id        = r_id_accum;
                res.msg_type       = r_type_hold;
                res.payload_length = r_length_accum;
                res.data_byte      = i_rx_byte;
                res.has_data       = 1'b1;
                res.last           = (count_inc == r_length_accum);
                if (count_inc == r_length_accum) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_field_idx     <= 2'd0;
            r_id_accum      <= '0;
            r_type_hold     <= '0;
            r_length_accum  <= '0;
            r_payload_count <= '0;
            r_start_byte    <= START_BYTE_RESET;
            r_out_valid     <= 1'b0;
            r_skid_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start_byte <= i_cfg_data;
            end
            if (rx_accept) begin
                r_phase         <= n_phase;
                r_field_idx     <= n_field_idx;
                r_id_accum      <= n_id_accum;
                r_type_hold     <= n_type_hold;
                r_length_accum  <= n_length_accum;
                r_payload_count <= n_payload_count;
            end
            // A waiting skid beat goes first; no byte is taken while it waits.
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= rx_accept && res_valid;
                end
            end else if (rx_accept && res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload registers of the output and skid stages.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= res;
            end
        end else if (rx_accept && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_node_id        = r_out.node_id;
    assign o_msg_type       = r_out.msg_type;
    assign o_payload_length = r_out.payload_length;
    assign o_data_byte      = r_out.data_byte;
    assign o_has_data       = r_out.has_data;
    assign o_last           = r_out.last;

    `PBD_ASSERT(a_skid_behind_out, !r_skid_valid || r_out_valid, "skid full with output empty")
    `PBD_ASSERT(a_data_count_below_len, r_phase != PH_DATA || r_payload_count < r_length_accum, "payload count reached length inside data phase")
    `PBD_ASSERT(a_empty_closes, !r_out_valid || r_out.has_data || r_out.last, "empty-packet result without last")
    `PBD_ASSERT_NEXT(a_skid_drains, r_skid_valid && !i_out_stall, !r_skid_valid, "skid beat not drained")

endmodule

`default_nettype wire
